FILE: rtl/core/spp_pkg.sv
// Shared types, constants and the sine lookup for the sine plasma pixel generator.
// No dependencies; every other file in rtl/core refers to it by scoped names.
`default_nettype none

package spp_pkg;

    // Radius path: squared distance scaled by 25 needs 18 bits, root needs half that.
    localparam int unsigned ROOT_W     = 9;
    localparam int unsigned LIM_W      = 2 * ROOT_W;
    localparam int unsigned SQRT_REM_W = ROOT_W + 3;
    localparam int unsigned DIST_W     = 13;

    // Sum of three sine terms, then of four (both fit 10 bits signed).
    localparam int unsigned SUM_W = 10;

    localparam logic [7:0]  STEP_X         = 8'd6;
    localparam logic [7:0]  STEP_Y         = 8'd7;
    localparam logic [7:0]  CENTER_TWICE   = 8'd63;
    localparam logic [LIM_W-1:0] RADIUS_SCALE_SQ = LIM_W'(25);

    localparam logic signed [10:0] VALUE_BASE = 11'sd150;
    localparam logic signed [10:0] VALUE_MIN  = 11'sd40;
    localparam logic signed [10:0] VALUE_MAX  = 11'sd255;

    localparam logic [7:0] HUE_SECTOR = 8'd43;
    localparam logic [7:0] REM_SCALE  = 8'd6;
    localparam logic [7:0] FULL_SCALE = 8'd255;

    typedef enum logic [2:0] {
        CFG_PHASE_X      = 3'd0,
        CFG_PHASE_Y      = 3'd1,
        CFG_PHASE_DIAG   = 3'd2,
        CFG_PHASE_RADIAL = 3'd3,
        CFG_HUE_BASE     = 3'd4,
        CFG_BOOST        = 3'd5
    } cfg_index_t;

    typedef enum logic [2:0] {
        REGION_RED_YEL  = 3'd0,
        REGION_YEL_GRN  = 3'd1,
        REGION_GRN_CYN  = 3'd2,
        REGION_CYN_BLU  = 3'd3,
        REGION_BLU_MAG  = 3'd4,
        REGION_MAG_RED  = 3'd5
    } hue_region_t;

    typedef struct packed {
        logic [7:0] phase_x;
        logic [7:0] phase_y;
        logic [7:0] phase_diag;
        logic [7:0] phase_radial;
        logic [7:0] hue_base;
        logic [5:0] brightness_boost;
    } cfg_t;

    typedef struct packed {
        logic                    valid;
        logic [LIM_W-1:0]        lim;
        logic signed [SUM_W-1:0] sum3;
    } front_word_t;

    typedef struct packed {
        logic                    valid;
        logic [ROOT_W-1:0]       root;
        logic signed [SUM_W-1:0] sum3;
    } root_word_t;

    typedef struct packed {
        logic        valid;
        logic [15:0] color;
    } pixel_word_t;

    // First quarter of round(127*sin(2*pi*i/256)), i = 0..64.
    localparam logic [6:0] QUARTER_WAVE [65] = '{
        7'd0,   7'd3,   7'd6,   7'd9,   7'd12,  7'd16,  7'd19,  7'd22,  7'd25,
        7'd28,  7'd31,  7'd34,  7'd37,  7'd40,  7'd43,  7'd46,  7'd49,  7'd51,
        7'd54,  7'd57,  7'd60,  7'd63,  7'd65,  7'd68,  7'd71,  7'd73,  7'd76,
        7'd78,  7'd81,  7'd83,  7'd85,  7'd88,  7'd90,  7'd92,  7'd94,  7'd96,
        7'd98,  7'd100, 7'd102, 7'd104, 7'd106, 7'd107, 7'd109, 7'd111, 7'd112,
        7'd113, 7'd115, 7'd116, 7'd117, 7'd118, 7'd120, 7'd121, 7'd122, 7'd122,
        7'd123, 7'd124, 7'd125, 7'd125, 7'd126, 7'd126, 7'd126, 7'd127, 7'd127,
        7'd127, 7'd127
    };

    // Full signed sine over 256 steps: fold into the quarter table, negate the back half.
    function automatic logic signed [7:0] sine_value(input logic [7:0] idx);
        logic [6:0] k;
        logic [6:0] fold;
        logic [7:0] mag;
        k    = idx[6:0];
        fold = (k <= 7'd64) ? k : 7'(8'd128 - {1'b0, k});
        mag  = {1'b0, QUARTER_WAVE[fold]};
        sine_value = $signed(idx[7] ? 8'(-mag) : mag);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/spp_front.sv
// Front stages: centre distance squared and the three coordinate sine terms.
// Depends on spp_pkg.
`default_nettype none

module spp_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                advance,
    input  wire logic                in_valid,
    input  wire logic [5:0]          pixel_x,
    input  wire logic [5:0]          pixel_y,
    input  wire spp_pkg::cfg_t       cfg,
    output spp_pkg::front_word_t     front
);

    // Stage A: offsets from centre (doubled), their squares, sine indexes.
    logic signed [7:0]             dx;
    logic signed [7:0]             dy;
    logic signed [15:0]            dx_sq;
    logic signed [15:0]            dy_sq;
    logic [6:0]                    xy_sum;
    logic [spp_pkg::DIST_W-1:0]    dist_next;
    logic [7:0]                    idx_x_next;
    logic [7:0]                    idx_y_next;
    logic [7:0]                    idx_diag_next;

    logic                          a_valid_reg;
    logic [spp_pkg::DIST_W-1:0]    dist_reg;
    logic [7:0]                    idx_x_reg;
    logic [7:0]                    idx_y_reg;
    logic [7:0]                    idx_diag_reg;

    // Stage B: scaled squared radius and partial sine sum.
    logic signed [7:0]             sin_x;
    logic signed [7:0]             sin_y;
    logic signed [7:0]             sin_diag;
    logic [spp_pkg::LIM_W-1:0]     lim_next;
    logic signed [spp_pkg::SUM_W-1:0] sum3_next;

    logic                          b_valid_reg;
    logic [spp_pkg::LIM_W-1:0]     lim_reg;
    logic signed [spp_pkg::SUM_W-1:0] sum3_reg;

    always_comb
    begin
        dx            = $signed({1'b0, pixel_x, 1'b0}) - $signed(spp_pkg::CENTER_TWICE);
        dy            = $signed({1'b0, pixel_y, 1'b0}) - $signed(spp_pkg::CENTER_TWICE);
        dx_sq         = dx * dx;
        dy_sq         = dy * dy;
        dist_next     = spp_pkg::DIST_W'($unsigned(dx_sq) + $unsigned(dy_sq));
        xy_sum        = {1'b0, pixel_x} + {1'b0, pixel_y};
        idx_x_next    = 8'({2'b00, pixel_x} * spp_pkg::STEP_X + cfg.phase_x);
        idx_y_next    = 8'({2'b00, pixel_y} * spp_pkg::STEP_Y + cfg.phase_y);
        idx_diag_next = {xy_sum[5:0], 2'b00} + cfg.phase_diag;
    end

    always_comb
    begin
        sin_x     = spp_pkg::sine_value(idx_x_reg);
        sin_y     = spp_pkg::sine_value(idx_y_reg);
        sin_diag  = spp_pkg::sine_value(idx_diag_reg);
        lim_next  = spp_pkg::LIM_W'({{(spp_pkg::LIM_W - spp_pkg::DIST_W){1'b0}}, dist_reg}
                    * spp_pkg::RADIUS_SCALE_SQ);
        sum3_next = {{2{sin_x[7]}}, sin_x} + {{2{sin_y[7]}}, sin_y}
                    + {{2{sin_diag[7]}}, sin_diag};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dist_reg     <= dist_next;
            idx_x_reg    <= idx_x_next;
            idx_y_reg    <= idx_y_next;
            idx_diag_reg <= idx_diag_next;
            lim_reg      <= lim_next;
            sum3_reg     <= sum3_next;
        end
    end

    assign front.valid = b_valid_reg;
    assign front.lim   = lim_reg;
    assign front.sum3  = sum3_reg;

endmodule

`default_nettype wire

FILE: rtl/core/spp_isqrt.sv
// Pipelined integer square root, one root bit per stage, partial sine sum carried along.
// Depends on spp_pkg.
`default_nettype none

module spp_isqrt (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 advance,
    input  wire spp_pkg::front_word_t front,
    output spp_pkg::root_word_t       root_word
);

    localparam int unsigned NSTAGE = spp_pkg::ROOT_W;

    logic [NSTAGE-1:0]                  valid_reg;
    logic [spp_pkg::LIM_W-1:0]          num_reg  [NSTAGE];
    logic [spp_pkg::SQRT_REM_W-1:0]     rem_reg  [NSTAGE];
    logic [spp_pkg::ROOT_W-1:0]         root_reg [NSTAGE];
    logic signed [spp_pkg::SUM_W-1:0]   sum3_reg [NSTAGE];

    for (genvar k = 0; k < NSTAGE; k++)
    begin : g_stage
        logic                               src_valid;
        logic [spp_pkg::LIM_W-1:0]          src_num;
        logic [spp_pkg::SQRT_REM_W-1:0]     src_rem;
        logic [spp_pkg::ROOT_W-1:0]         src_root;
        logic signed [spp_pkg::SUM_W-1:0]   src_sum3;
        logic [spp_pkg::SQRT_REM_W-1:0]     rem_shift;
        logic [spp_pkg::SQRT_REM_W-1:0]     trial;
        logic                               fits;
        logic [spp_pkg::SQRT_REM_W-1:0]     rem_next;
        logic [spp_pkg::ROOT_W-1:0]         root_next;
        logic [spp_pkg::LIM_W-1:0]          num_next;

        if (k == 0)
        begin : g_first
            assign src_valid = front.valid;
            assign src_num   = front.lim;
            assign src_rem   = '0;
            assign src_root  = '0;
            assign src_sum3  = front.sum3;
        end
        else
        begin : g_next
            assign src_valid = valid_reg[k-1];
            assign src_num   = num_reg[k-1];
            assign src_rem   = rem_reg[k-1];
            assign src_root  = root_reg[k-1];
            assign src_sum3  = sum3_reg[k-1];
        end

        // Bring down the next two radicand bits and try (4*root + 1).
        always_comb
        begin
            rem_shift = {src_rem[spp_pkg::SQRT_REM_W-3:0],
                         src_num[spp_pkg::LIM_W-1 -: 2]};
            trial     = spp_pkg::SQRT_REM_W'({src_root, 2'b01});
            fits      = (rem_shift >= trial);
            rem_next  = fits ? (rem_shift - trial) : rem_shift;
            root_next = {src_root[spp_pkg::ROOT_W-2:0], fits};
            num_next  = {src_num[spp_pkg::LIM_W-3:0], 2'b00};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (advance)
            begin
                valid_reg[k] <= src_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                num_reg[k]  <= num_next;
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                sum3_reg[k] <= src_sum3;
            end
        end
    end

    assign root_word.valid = valid_reg[NSTAGE-1];
    assign root_word.root  = root_reg[NSTAGE-1];
    assign root_word.sum3  = sum3_reg[NSTAGE-1];

endmodule

`default_nettype wire

FILE: rtl/core/spp_color.sv
// Back stages: radial sine term, hue and value, integer HSV to RGB565.
// Depends on spp_pkg.
`default_nettype none

module spp_color (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                advance,
    input  wire spp_pkg::root_word_t root_word,
    input  wire spp_pkg::cfg_t       cfg,
    output spp_pkg::pixel_word_t     pixel
);

    // Stage C: radius rounding, radial sine, full plasma sum.
    logic [spp_pkg::ROOT_W:0]           rad_wide;
    logic [7:0]                         rad_idx;
    logic signed [7:0]                  sin_rad;
    logic signed [spp_pkg::SUM_W-1:0]   sum_next;
    logic                               c_valid_reg;
    logic signed [spp_pkg::SUM_W-1:0]   sum_reg;

    // Stage D: hue and clamped value.
    logic [7:0]                         hue_next;
    logic signed [10:0]                 v_wide;
    logic [7:0]                         v_next;
    logic                               d_valid_reg;
    logic [7:0]                         hue_reg;
    logic [7:0]                         v_d_reg;

    // Stage E: hue region and remainder.
    spp_pkg::hue_region_t               region_next;
    logic [7:0]                         base_next;
    logic [7:0]                         rem_next;
    logic                               e_valid_reg;
    spp_pkg::hue_region_t               region_e_reg;
    logic [7:0]                         rem_reg;
    logic [7:0]                         v_e_reg;

    // Stage F: ramp products.
    logic [15:0]                        q_prod;
    logic [15:0]                        t_prod;
    logic                               f_valid_reg;
    spp_pkg::hue_region_t               region_f_reg;
    logic [7:0]                         v_f_reg;
    logic [7:0]                         q_reg;
    logic [7:0]                         t_reg;

    logic [7:0]                         red;
    logic [7:0]                         green;
    logic [7:0]                         blue;

    always_comb
    begin
        rad_wide = {1'b0, root_word.root} + (spp_pkg::ROOT_W + 1)'(1);
        rad_idx  = rad_wide[8:1] + cfg.phase_radial;
        sin_rad  = spp_pkg::sine_value(rad_idx);
        sum_next = root_word.sum3 + {{2{sin_rad[7]}}, sin_rad};
    end

    // Floor shifts of the sum are plain part-selects of the two's complement word.
    always_comb
    begin
        hue_next = cfg.hue_base + sum_reg[9:2];
        v_wide   = spp_pkg::VALUE_BASE + 11'($signed(sum_reg[9:3]))
                   + $signed({5'b00000, cfg.brightness_boost});
        priority if (v_wide < spp_pkg::VALUE_MIN)
            v_next = 8'(spp_pkg::VALUE_MIN);
        else if (v_wide > spp_pkg::VALUE_MAX)
            v_next = 8'(spp_pkg::VALUE_MAX);
        else
            v_next = v_wide[7:0];
    end

    always_comb
    begin
        priority if (hue_reg < spp_pkg::HUE_SECTOR)
        begin
            region_next = spp_pkg::REGION_RED_YEL;
            base_next   = 8'd0;
        end
        else if (hue_reg < 8'(2 * spp_pkg::HUE_SECTOR))
        begin
            region_next = spp_pkg::REGION_YEL_GRN;
            base_next   = spp_pkg::HUE_SECTOR;
        end
        else if (hue_reg < 8'(3 * spp_pkg::HUE_SECTOR))
        begin
            region_next = spp_pkg::REGION_GRN_CYN;
            base_next   = 8'(2 * spp_pkg::HUE_SECTOR);
        end
        else if (hue_reg < 8'(4 * spp_pkg::HUE_SECTOR))
        begin
            region_next = spp_pkg::REGION_CYN_BLU;
            base_next   = 8'(3 * spp_pkg::HUE_SECTOR);
        end
        else if (hue_reg < 8'(5 * spp_pkg::HUE_SECTOR))
        begin
            region_next = spp_pkg::REGION_BLU_MAG;
            base_next   = 8'(4 * spp_pkg::HUE_SECTOR);
        end
        else
        begin
            region_next = spp_pkg::REGION_MAG_RED;
            base_next   = 8'(5 * spp_pkg::HUE_SECTOR);
        end
        rem_next = 8'((hue_reg - base_next) * spp_pkg::REM_SCALE);
    end

    always_comb
    begin
        q_prod = {8'd0, v_e_reg} * {8'd0, spp_pkg::FULL_SCALE - rem_reg};
        t_prod = {8'd0, v_e_reg} * {8'd0, rem_reg};
    end

    // Pick the channel triple for the region and pack 5:6:5.
    always_comb
    begin
        unique case (region_f_reg)
            spp_pkg::REGION_RED_YEL:
            begin
                red = v_f_reg; green = t_reg;   blue = 8'd0;
            end
            spp_pkg::REGION_YEL_GRN:
            begin
                red = q_reg;   green = v_f_reg; blue = 8'd0;
            end
            spp_pkg::REGION_GRN_CYN:
            begin
                red = 8'd0;    green = v_f_reg; blue = t_reg;
            end
            spp_pkg::REGION_CYN_BLU:
            begin
                red = 8'd0;    green = q_reg;   blue = v_f_reg;
            end
            spp_pkg::REGION_BLU_MAG:
            begin
                red = t_reg;   green = 8'd0;    blue = v_f_reg;
            end
            spp_pkg::REGION_MAG_RED:
            begin
                red = v_f_reg; green = 8'd0;    blue = q_reg;
            end
            default:
            begin
                red = 8'd0;    green = 8'd0;    blue = 8'd0;
            end
        endcase
        pixel.valid = f_valid_reg;
        pixel.color = {red[7:3], green[7:2], blue[7:3]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            c_valid_reg <= root_word.valid;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
            f_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sum_reg      <= sum_next;
            hue_reg      <= hue_next;
            v_d_reg      <= v_next;
            region_e_reg <= region_next;
            rem_reg      <= rem_next;
            v_e_reg      <= v_d_reg;
            region_f_reg <= region_e_reg;
            v_f_reg      <= v_e_reg;
            q_reg        <= q_prod[15:8];
            t_reg        <= t_prod[15:8];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/sine_plasma_pixel_generator.sv
// Sine plasma pixel generator: 64x64 coordinate in, RGB565 plasma color out.
// Top level; depends on spp_pkg, spp_front, spp_isqrt and spp_color.
//
// Usage:
//   - Input channel (in_valid / in_stall, pixel_x, pixel_y): one word per pixel.
//     A word is taken on a clock edge with in_valid high and in_stall low.
//   - Output channel (out_valid / out_stall, pixel_color): one RGB565 word per
//     input word, in order. The receiver holds out_stall high to hold a word.
//   - Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data): writes one of
//     phase_x, phase_y, phase_diag, phase_radial, hue_base, brightness_boost.
//     cfg_ready is always high. Write only while no pixel is in flight.
//   - Throughput: one pixel per clock while in_stall is low. Pipeline depth from
//     the accepting edge to pixel_color showing at the output: the nine-stage
//     square root of the centre distance sets most of that depth.
//   - Reset (rst_n low, asynchronous): clears all valid bits, including those of
//     the output and skid registers, and every config register to zero.
//   - Stall: a two-entry output buffer absorbs the word leaving the pipeline;
//     once its skid entry fills, in_stall rises and the whole pipeline holds
//     until the receiver drains it. in_stall is a register output.
`default_nettype none

module sine_plasma_pixel_generator (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [5:0]  pixel_x,
    input  wire logic [5:0]  pixel_y,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [15:0]      pixel_color,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    spp_pkg::cfg_t        cfg_reg;
    spp_pkg::cfg_t        cfg_next;

    logic                 advance;
    spp_pkg::front_word_t front;
    spp_pkg::root_word_t  root_word;
    spp_pkg::pixel_word_t pixel;

    logic                 take;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [15:0]          out_color_reg;
    logic [15:0]          out_color_next;
    logic                 skid_valid_reg;
    logic                 skid_valid_next;
    logic [15:0]          skid_color_reg;
    logic [15:0]          skid_color_next;

    // Config register file; decode the index, drop writes to unknown indexes.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (spp_pkg::cfg_index_t'(cfg_index))
                spp_pkg::CFG_PHASE_X:      cfg_next.phase_x          = cfg_data;
                spp_pkg::CFG_PHASE_Y:      cfg_next.phase_y          = cfg_data;
                spp_pkg::CFG_PHASE_DIAG:   cfg_next.phase_diag       = cfg_data;
                spp_pkg::CFG_PHASE_RADIAL: cfg_next.phase_radial     = cfg_data;
                spp_pkg::CFG_HUE_BASE:     cfg_next.hue_base         = cfg_data;
                spp_pkg::CFG_BOOST:        cfg_next.brightness_boost = cfg_data[5:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_ready = 1'b1;

    // The pipeline moves whenever the skid entry is free; every word leaving it
    // then lands in either the output or the skid register.
    assign advance  = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    spp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_valid (in_valid),
        .pixel_x  (pixel_x),
        .pixel_y  (pixel_y),
        .cfg      (cfg_reg),
        .front    (front)
    );

    spp_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .front     (front),
        .root_word (root_word)
    );

    spp_color u_color (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .root_word (root_word),
        .cfg       (cfg_reg),
        .pixel     (pixel)
    );

    // Output register plus skid entry.
    always_comb
    begin
        take            = out_valid_reg && !out_stall;
        out_valid_next  = out_valid_reg;
        out_color_next  = out_color_reg;
        skid_valid_next = skid_valid_reg;
        skid_color_next = skid_color_reg;
        priority if (skid_valid_reg)
        begin
            // Pipeline is held; refill the output from the skid once taken.
            if (take)
            begin
                out_color_next  = skid_color_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (pixel.valid)
        begin
            if (!out_valid_reg || take)
            begin
                out_valid_next = 1'b1;
                out_color_next = pixel.color;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_color_next = pixel.color;
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_color_reg  <= out_color_next;
        skid_color_reg <= skid_color_next;
    end

    assign out_valid   = out_valid_reg;
    assign pixel_color = out_color_reg;

endmodule

`default_nettype wire
